>>> rtl/hds_pkg.sv
package hds_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int COEFF_W    = 16;
    localparam int GRID_SIDE_W = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int LINE_DEPTH = MAX_SIDE + 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(MAX_SIDE + 3);
    localparam int SIDE_CMP_W = (GRID_SIDE_W > CNT_W) ? GRID_SIDE_W : CNT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_BITS   = DATA_W + 2 * IDX_W;
    localparam int TDATA_IN_W = ((DATA_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEFF_X   = 2'd0,
        CFG_COEFF_Y   = 2'd1,
        CFG_GRID_SIDE = 2'd2
    } cfg_index_t;

    // one interior cell with its four neighbors, ready for the arithmetic
    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] down;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } stencil_t;

    typedef struct packed {
        logic     valid;
        stencil_t data;
    } stencil_beat_t;

endpackage

>>> rtl/hds_front.sv
module hds_front
    import hds_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [GRID_SIDE_W-1:0]   grid_side,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] cell_value,
    input  logic                     frame_start,
    input  logic                     q_full,
    output stencil_beat_t            push
);

    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;

    logic                     a_valid_reg;
    logic signed [DATA_W-1:0] a_x_reg;
    logic [ADDR_W-1:0]        a_addr_reg;
    logic                     a_emit_reg;
    logic [IDX_W-1:0]         a_row_reg;
    logic [IDX_W-1:0]         a_col_reg;
    logic                     a_last_reg;

    logic                     fwd_hit_reg;
    logic [2*DATA_W-1:0]      fwd_data_reg;
    logic [2*DATA_W-1:0]      rd_reg;
    logic [2*DATA_W-1:0]      line_mem [LINE_DEPTH];

    logic signed [DATA_W-1:0] w0_2_reg, w1_1_reg, w1_2_reg, w2_2_reg;

    logic [SIDE_CMP_W-1:0] side_wide;
    logic [CNT_W-1:0]      side;
    logic [CNT_W-1:0]      pad_side;
    logic                  restart;
    logic [CNT_W-1:0]      r, c;
    logic                  en, accept, proc;
    logic [2*DATA_W-1:0]   entry;
    logic signed [DATA_W-1:0] above, mid;

    assign en       = !q_full;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign proc     = en && a_valid_reg;

    always_comb begin
        side_wide = SIDE_CMP_W'(grid_side);
        if (side_wide == '0) begin
            side = CNT_W'(1);
        end else if (side_wide > SIDE_CMP_W'(MAX_SIDE)) begin
            side = CNT_W'(MAX_SIDE);
        end else begin
            side = side_wide[CNT_W-1:0];
        end
        pad_side = side + CNT_W'(2);
        restart  = frame_start || (row_reg >= pad_side) || (col_reg >= pad_side);
        r        = restart ? '0 : row_reg;
        c        = restart ? '0 : col_reg;
        row_next = r;
        col_next = c + CNT_W'(1);
        if (col_next >= pad_side) begin
            col_next = '0;
            row_next = r + CNT_W'(1);
            if (row_next >= pad_side) begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                a_valid_reg <= 1'b1;
                // the entry being written back this edge is newer than the read
                fwd_hit_reg <= proc && (a_addr_reg == c[ADDR_W-1:0]);
            end else if (en) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_x_reg      <= cell_value;
            a_addr_reg   <= c[ADDR_W-1:0];
            a_emit_reg   <= (r >= CNT_W'(2)) && (c >= CNT_W'(2));
            a_row_reg    <= IDX_W'(r - CNT_W'(2));
            a_col_reg    <= IDX_W'(c - CNT_W'(2));
            a_last_reg   <= (r == pad_side - CNT_W'(1)) && (c == pad_side - CNT_W'(1));
            fwd_data_reg <= {mid, a_x_reg};
        end
    end

    // line store: upper row in the high half, middle row in the low half
    always_ff @(posedge aclk) begin
        if (proc) begin
            line_mem[a_addr_reg] <= {mid, a_x_reg};
        end
        if (accept) begin
            rd_reg <= line_mem[c[ADDR_W-1:0]];
        end
    end

    assign entry = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign above = entry[2*DATA_W-1:DATA_W];
    assign mid   = entry[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (proc) begin
            w0_2_reg <= above;
            w1_1_reg <= w1_2_reg;
            w1_2_reg <= mid;
            w2_2_reg <= a_x_reg;
        end
    end

    always_comb begin
        push.valid      = proc && a_emit_reg;
        push.data.u     = w1_2_reg;
        push.data.up    = w0_2_reg;
        push.data.down  = w2_2_reg;
        push.data.left  = w1_1_reg;
        push.data.right = mid;
        push.data.row   = a_row_reg;
        push.data.col   = a_col_reg;
        push.data.last  = a_last_reg;
    end

endmodule

>>> rtl/hds_queue.sv
module hds_queue
    import hds_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  stencil_beat_t push,
    input  logic          pop,
    output logic          full,
    output stencil_beat_t head
);

    stencil_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push.valid && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (!push.valid && do_pop) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

>>> rtl/hds_back.sv
module hds_back
    import hds_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [COEFF_W-1:0]       coeff_x,
    input  logic [COEFF_W-1:0]       coeff_y,
    input  stencil_beat_t            head,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] new_value,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic                     last
);

    localparam int DIFF_W = DATA_W + 2;
    localparam int PROD_W = COEFF_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Y_W    = SUM_W - FRAC_W;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } tag_t;

    logic adv;

    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_u_reg;
    logic signed [DIFF_W-1:0] s1_dv_reg, s1_dh_reg;
    tag_t                     s1_tag_reg;

    logic                     s2_valid_reg;
    logic signed [DATA_W-1:0] s2_u_reg;
    logic signed [PROD_W-1:0] s2_px_reg, s2_py_reg;
    tag_t                     s2_tag_reg;

    logic                     s3_valid_reg;
    logic signed [Y_W-1:0]    s3_y_reg;
    tag_t                     s3_tag_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    tag_t                     out_tag_reg;

    logic signed [DIFF_W-1:0] s1_dv_next, s1_dh_next, two_u;
    logic signed [PROD_W-1:0] s2_px_next, s2_py_next;
    logic signed [SUM_W-1:0]  sum;
    logic [Y_W-DATA_W:0]      y_hi;
    logic signed [DATA_W-1:0] out_value_next;

    // the whole pipe moves unless a finished beat waits on the output
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && head.valid;

    always_comb begin
        two_u      = DIFF_W'(head.data.u) <<< 1;
        s1_dv_next = DIFF_W'(head.data.up) + DIFF_W'(head.data.down) - two_u;
        s1_dh_next = DIFF_W'(head.data.left) + DIFF_W'(head.data.right) - two_u;
        s2_px_next = PROD_W'($signed({1'b0, coeff_x})) * PROD_W'(s1_dv_reg);
        s2_py_next = PROD_W'($signed({1'b0, coeff_y})) * PROD_W'(s1_dh_reg);
        sum = (SUM_W'(s2_u_reg) <<< FRAC_W) + SUM_W'(s2_px_reg) + SUM_W'(s2_py_reg)
            + SUM_W'(1 << (FRAC_W - 1));
        // saturate when the bits above the result width are not a sign run
        y_hi = s3_y_reg[Y_W-1:DATA_W-1];
        if ((&y_hi) || !(|y_hi)) begin
            out_value_next = s3_y_reg[DATA_W-1:0];
        end else if (s3_y_reg[Y_W-1]) begin
            out_value_next = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            out_value_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= head.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_u_reg      <= head.data.u;
            s1_dv_reg     <= s1_dv_next;
            s1_dh_reg     <= s1_dh_next;
            s1_tag_reg    <= '{row: head.data.row, col: head.data.col, last: head.data.last};
            s2_u_reg      <= s1_u_reg;
            s2_px_reg     <= s2_px_next;
            s2_py_reg     <= s2_py_next;
            s2_tag_reg    <= s1_tag_reg;
            s3_y_reg      <= sum[SUM_W-1:FRAC_W];
            s3_tag_reg    <= s2_tag_reg;
            out_value_reg <= out_value_next;
            out_tag_reg   <= s3_tag_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign new_value = out_value_reg;
    assign out_row   = out_tag_reg.row;
    assign out_col   = out_tag_reg.col;
    assign last      = out_tag_reg.last;

endmodule

>>> rtl/heat_diffusion_stencil_top.sv
// Five-point Jacobi heat stencil over a raster stream of a padded grid (interior side
// grid_side, one ghost ring, Q16.16 cells; s_tuser marks the first padded cell of a pass).
// One cell is taken per clock while the queue has room; the block emits one beat per
// interior cell once the cell below-right of it has arrived, with the last interior cell
// marked by m_tlast. Rate is set by the line store, read once and written back once per
// cell in the same cycle (a write back to the address being read is forwarded), which
// allows one cell every cycle. On its way to m_tdata a cell passes the line store read at
// the accept edge, the window registers that form it and queue it, then a four-stage
// arithmetic pipe (second differences, coefficient multiplies, rounding sum, saturation).
// A four-beat queue between window front end and arithmetic lets either side stall alone.
// Configuration: index 0 coeff_x (vertical weight, Q0.16), 1 coeff_y (horizontal weight,
// Q0.16), 2 grid_side (1..1024, 0 is taken as 1, larger values as 1024). Write only idle.
module heat_diffusion_stencil_top
    import hds_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // [31:0] cell_value
    input  logic                    s_tuser,   // frame_start
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_OUT_W-1:0]  m_tdata,   // [31:0] new_value, [41:32] out_row,
                                               // [51:42] out_col, [55:52] zero
    output logic                    m_tlast
);

    logic [COEFF_W-1:0]     coeff_x_reg;
    logic [COEFF_W-1:0]     coeff_y_reg;
    logic [GRID_SIDE_W-1:0] grid_side_reg;

    stencil_beat_t            push;
    stencil_beat_t            head;
    logic                     q_full;
    logic                     pop;
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_x_reg   <= COEFF_W'(6554);
            coeff_y_reg   <= COEFF_W'(6554);
            grid_side_reg <= GRID_SIDE_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COEFF_X:   coeff_x_reg   <= cfg_wdata[COEFF_W-1:0];
                CFG_COEFF_Y:   coeff_y_reg   <= cfg_wdata[COEFF_W-1:0];
                CFG_GRID_SIDE: grid_side_reg <= cfg_wdata[GRID_SIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hds_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .grid_side   (grid_side_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cell_value  ($signed(s_tdata[DATA_W-1:0])),
        .frame_start (s_tuser),
        .q_full      (q_full),
        .push        (push)
    );

    hds_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .head    (head)
    );

    hds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coeff_x   (coeff_x_reg),
        .coeff_y   (coeff_y_reg),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .new_value (new_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (m_tlast)
    );

    assign m_tdata = TDATA_OUT_W'({out_col, out_row, new_value});

endmodule

>>> tb/sv/hds_stencil_checker.sv
`timescale 1ns / 100ps

module hds_stencil_checker
    import hds_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // [31:0] cell_value
    input  logic                    s_tuser,   // frame_start
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [TDATA_OUT_W-1:0]  m_tdata,   // [31:0] new_value, [41:32] out_row,
                                               // [51:42] out_col, [55:52] zero
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      pending_count
);

    localparam longint TEMP_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint TEMP_MIN = -TEMP_MAX - 1;
    localparam int     MAX_PRINTS = 40;

    typedef struct {
        logic [DATA_W-1:0] temp;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } cell_update_t;

    logic [COEFF_W-1:0]       coeff_vert;
    logic [COEFF_W-1:0]       coeff_horz;
    logic [GRID_SIDE_W-1:0]   side_reg;
    logic signed [DATA_W-1:0] line_above [LINE_DEPTH];
    logic signed [DATA_W-1:0] line_mid [LINE_DEPTH];
    logic signed [DATA_W-1:0] win [3][3];
    int unsigned              next_row;
    int unsigned              next_col;
    cell_update_t             updates_due [$];
    int                       mismatches = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // advance the padded-grid position by one cell and queue an updated interior cell when the window holds one
    task automatic predict_heat_step(input logic signed [DATA_W-1:0] cell_val,
                                     input logic frame_start);
        int unsigned side;
        int unsigned pad;
        int unsigned r;
        int unsigned c;
        logic signed [DATA_W-1:0] above;
        logic signed [DATA_W-1:0] mid;
        longint u;
        longint dv;
        longint dh;
        longint acc;
        cell_update_t upd;

        side = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        pad = side + 2;
        if (frame_start || next_row >= pad || next_col >= pad) begin
            next_row = 0;
            next_col = 0;
        end
        r = next_row;
        c = next_col;

        above = line_above[c];
        mid = line_mid[c];
        line_above[c] = mid;
        line_mid[c] = cell_val;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = mid;
        win[2][2] = cell_val;

        if (r >= 2 && c >= 2) begin
            u = win[1][1];
            dv = longint'(win[0][1]) + longint'(win[2][1]) - 2 * u;
            dh = longint'(win[1][0]) + longint'(win[1][2]) - 2 * u;
            acc = (u <<< FRAC_W) + longint'(coeff_vert) * dv + longint'(coeff_horz) * dh;
            // round half up, then clamp to the cell range
            acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (acc > TEMP_MAX)
                acc = TEMP_MAX;
            if (acc < TEMP_MIN)
                acc = TEMP_MIN;
            upd.temp = acc[DATA_W-1:0];
            upd.row = IDX_W'(r - 2);
            upd.col = IDX_W'(c - 2);
            upd.last = (r == pad - 1) && (c == pad - 1);
            updates_due.push_back(upd);
        end

        c++;
        if (c >= pad) begin
            c = 0;
            r++;
            if (r >= pad)
                r = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    task automatic check_update(input logic [TDATA_OUT_W-1:0] data, input logic tl);
        cell_update_t want;

        if (updates_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat data=%h last=%b", data, tl));
            return;
        end
        want = updates_due.pop_front();
        if (data[DATA_W-1:0] !== want.temp
                || data[DATA_W +: IDX_W] !== want.row
                || data[DATA_W+IDX_W +: IDX_W] !== want.col
                || tl !== want.last)
            report_mismatch($sformatf(
                "got value %h row %0d col %0d last %b, want value %h row %0d col %0d last %b",
                data[DATA_W-1:0], data[DATA_W +: IDX_W], data[DATA_W+IDX_W +: IDX_W], tl,
                want.temp, want.row, want.col, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            coeff_vert = 16'd6554;
            coeff_horz = 16'd6554;
            side_reg = 11'd64;
            next_row = 0;
            next_col = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            updates_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COEFF_X:   coeff_vert = cfg_wdata[COEFF_W-1:0];
                    CFG_COEFF_Y:   coeff_horz = cfg_wdata[COEFF_W-1:0];
                    CFG_GRID_SIDE: side_reg = cfg_wdata[GRID_SIDE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_heat_step(s_tdata[DATA_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
                check_update(m_tdata, m_tlast);
        end
        pending_count <= updates_due.size();
        fail_count <= mismatches;
    end

endmodule

>>> tb/sv/tb_heat_diffusion_stencil_top.sv
`timescale 1ns / 100ps

module tb_heat_diffusion_stencil_top;
    import hds_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_CELLS   = 1600;
    localparam int WIDEST_SIDE    = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;  // decodes to no register
    localparam logic [31:0] TEMP_HI = 32'h7FFF_FFFF;
    localparam logic [31:0] TEMP_LO = 32'h8000_0000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_tdata;
    logic                    m_tlast;

    int fail_count;
    int pending_count;
    int gap_pct = 0;
    int stall_pct = 0;
    int random_cells = 0;
    logic [GRID_SIDE_W-1:0] side_now = 11'd64;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    heat_diffusion_stencil_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    hds_stencil_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 69; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 69; end
            default: begin gap_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // keep cfg_we high across the whole burst, then drop it once
    task automatic write_regs(input logic [COEFF_W-1:0] cv, input logic [COEFF_W-1:0] ch,
                              input logic [GRID_SIDE_W-1:0] side);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COEFF_X;
        cfg_wdata <= cv;
        @(posedge aclk);
        cfg_index <= CFG_COEFF_Y;
        cfg_wdata <= ch;
        @(posedge aclk);
        cfg_index <= CFG_GRID_SIDE;
        cfg_wdata <= CFG_DATA_W'(side);
        @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        side_now = side;
    endtask

    task automatic send_cell(input logic [31:0] value, input logic fs);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= fs;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // drop valid, wait out the results in flight, then let the pipe go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int pad_side();
        int side;
        side = (side_now == 0) ? 1 : (side_now > MAX_SIDE) ? MAX_SIDE : side_now;
        return side + 2;
    endfunction

    function automatic logic [31:0] pick_cell(input int style);
        logic [31:0] r;
        r = $urandom;
        case (style)
            0: return {{11{r[20]}}, r[20:0]};
            1: return r;
            default: begin
                case (r[1:0])
                    2'd0: return TEMP_HI;
                    2'd1: return TEMP_LO;
                    2'd2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // a noisy pass may skip its start mark or restart somewhere in the middle
    task automatic send_pass(input int cells, input int style, input bit noisy);
        logic fs;
        for (int k = 0; k < cells; k++) begin
            if (k == 0)
                fs = noisy ? ($urandom_range(9) != 0) : 1'b1;
            else
                fs = noisy && ($urandom_range(299) == 0);
            send_cell(pick_cell(style), fs);
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int cells;
        int pick;
        logic [COEFF_W-1:0] cv;
        logic [COEFF_W-1:0] ch;
        logic [GRID_SIDE_W-1:0] side;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // side 0 runs as side 1: hot center between cold ghosts, vertical weight only
        set_idling(0);
        write_regs(16'hFFFF, 16'h0000, 11'd0);
        for (int k = 0; k < 9; k++)
            send_cell((k == 4) ? TEMP_HI : TEMP_LO, k == 0);
        settle();

        // two cells that follow the wrap without a mark, then a restart mid pass
        set_idling(3);
        write_regs(16'h0000, 16'hFFFF, 11'd1);
        send_cell(TEMP_HI, 1'b0);
        send_cell(TEMP_LO, 1'b0);
        for (int k = 0; k < 9; k++)
            send_cell((k == 4) ? TEMP_LO : TEMP_HI, k == 0);
        settle();

        // fill both line rows across the widest grid, so an unmarked pass that carries
        // on into a wider grid only reads entries that were written
        set_idling(2);
        write_regs(16'($urandom), 16'($urandom), 11'(WIDEST_SIDE));
        send_pass(2 * pad_side(), 0, 1'b0);
        settle();

        phase = 0;
        while (random_cells < RANDOM_CELLS) begin
            set_idling(phase % 4);
            pick = $urandom_range(99);
            if (pick < 70)
                side = 11'($urandom_range(6, 1));
            else if (pick < 90)
                side = 11'($urandom_range(WIDEST_SIDE, 7));
            else if (pick < 95)
                side = 11'd0;
            else
                side = 11'd1;
            cv = ($urandom_range(4) == 0) ? {COEFF_W{1'($urandom_range(1))}}
                                          : 16'($urandom);
            ch = ($urandom_range(4) == 0) ? {COEFF_W{1'($urandom_range(1))}}
                                          : 16'($urandom);
            write_regs(cv, ch, side);
            repeat ($urandom_range(3, 1)) begin
                cells = pad_side() * pad_side();
                if ($urandom_range(7) == 0)
                    cells = $urandom_range(cells, 1);
                send_pass(cells, $urandom_range(2), 1'b1);
                random_cells += cells;
            end
            settle();
            phase++;
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hds_pkg.sv
rtl/hds_front.sv
rtl/hds_queue.sv
rtl/hds_back.sv
rtl/heat_diffusion_stencil_top.sv
tb/sv/hds_stencil_checker.sv
tb/sv/tb_heat_diffusion_stencil_top.sv
